// ===== hdl/poi_pkg.sv =====
// Package: shared constants, state type and arithmetic helpers for the odometry integrator.
`default_nettype none
package poi_pkg;

    // Default configuration
    localparam int CORDIC_STEPS_DEF      = 16;
    localparam int HEADING_FRAC_BITS_DEF = 10;

    // Field widths
    localparam int DT_W   = 16;
    localparam int VEL_W  = 16;
    localparam int YAW_W  = 19;
    localparam int POS_W  = 48;
    localparam int ANG_W  = 16;
    localparam int Q15_W  = 16;

    // CORDIC datapath widths
    localparam int CX_W   = 34;   // Q2.30 x/y with growth headroom
    localparam int CZ_W   = 33;   // residual phase
    localparam int STEP_W = 5;    // indexes the 24-entry arctangent table
    localparam int ATAN_N = 24;

    // Shared multiplier operand widths
    localparam int MA_W   = 33;
    localparam int MB_W   = 19;
    localparam int MP_W   = MA_W + MB_W;

    // CORDIC start gain in Q2.30
    localparam logic signed [CX_W-1:0] Q30_GAIN = CX_W'(652032874);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT1,
        S_FIN1,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_HEAD,
        S_ROT2,
        S_DONE
    } t_state;

    // Arctangent table, 2^32 per turn
    function automatic logic [CZ_W-1:0] atan_q(input logic [STEP_W-1:0] idx);
        logic [CZ_W-1:0] v;
        unique case (idx)
            5'd0:    v = CZ_W'(536870912);
            5'd1:    v = CZ_W'(316933406);
            5'd2:    v = CZ_W'(167458907);
            5'd3:    v = CZ_W'(85004756);
            5'd4:    v = CZ_W'(42667331);
            5'd5:    v = CZ_W'(21354465);
            5'd6:    v = CZ_W'(10679838);
            5'd7:    v = CZ_W'(5340245);
            5'd8:    v = CZ_W'(2670163);
            5'd9:    v = CZ_W'(1335087);
            5'd10:   v = CZ_W'(667544);
            5'd11:   v = CZ_W'(333772);
            5'd12:   v = CZ_W'(166886);
            5'd13:   v = CZ_W'(83443);
            5'd14:   v = CZ_W'(41722);
            5'd15:   v = CZ_W'(20861);
            5'd16:   v = CZ_W'(10430);
            5'd17:   v = CZ_W'(5215);
            5'd18:   v = CZ_W'(2608);
            5'd19:   v = CZ_W'(1304);
            5'd20:   v = CZ_W'(652);
            5'd21:   v = CZ_W'(326);
            5'd22:   v = CZ_W'(163);
            5'd23:   v = CZ_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round half up from Q2.30 to Q1.15 and saturate
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CX_W:0] v);
        logic signed [CX_W:0]    sum;
        logic signed [CX_W-15:0] r;
        logic signed [Q15_W-1:0] res;
        sum = v + (CX_W+1)'(16384);
        r   = (CX_W-14)'(sum >>> 15);
        if (r > (CX_W-14)'(32767))
            res = 16'sh7fff;
        else if (r < -(CX_W-14)'(32768))
            res = 16'sh8000;
        else
            res = r[Q15_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/poi_if.sv =====
// Interfaces: input sample channel and result channel with valid/ready handshake.
`default_nettype none
interface poi_in_if;
    import poi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [DT_W-1:0]          dt_ticks;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [YAW_W-1:0]  yaw_rate;
    modport source (output valid, dt_ticks, vel_x, vel_y, yaw_rate, input ready);
    modport sink   (input valid, dt_ticks, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface poi_out_if;
    import poi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [ANG_W-1:0]         heading_angle;
    logic signed [Q15_W-1:0]  quat_z;
    logic signed [Q15_W-1:0]  quat_w;
    modport source (output valid, pos_x, pos_y, heading_angle, quat_z, quat_w, input ready);
    modport sink   (input valid, pos_x, pos_y, heading_angle, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

// ===== hdl/planar_odometry_integrator.sv =====
// One item is processed at a time; the next is taken only after the last result
// has entered the output register. The single CORDIC iteration unit runs twice
// per item and the one shared multiplier runs seven times.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears position, heading and all handshake state.
`default_nettype none
module planar_odometry_integrator
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS      = CORDIC_STEPS_DEF,
    parameter int HEADING_FRAC_BITS = HEADING_FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    poi_in_if.sink     i_in,
    poi_out_if.source  o_res
);

    localparam int HB    = 17 + HEADING_FRAC_BITS;
    localparam int F     = HEADING_FRAC_BITS;
    localparam int NSTEP = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam logic [STEP_W-1:0] LAST = STEP_W'(NSTEP - 1);
    localparam int SH_L  = (F >= 10) ? F - 10 : 0;
    localparam int SH_R  = (F < 10) ? 10 - F : 0;

    t_state r_state, n_state;

    // Captured item
    logic [DT_W-1:0]         r_dt;
    logic signed [VEL_W-1:0] r_vx, r_vy;
    logic signed [YAW_W-1:0] r_wz;

    // State
    logic [POS_W-1:0] r_x, r_y;
    logic [HB-1:0]    r_head;

    // CORDIC unit
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic signed [CZ_W-1:0] r_cz;
    logic [1:0]             r_q;
    logic [STEP_W-1:0]      r_step;

    // Products
    logic signed [Q15_W-1:0] r_sin, r_cos;
    logic signed [31:0]      r_m0, r_m1, r_m2, r_m3;
    logic signed [MP_W-1:0]  r_prod;

    // Output register
    logic                    r_ov;
    logic [POS_W-1:0]        r_ox, r_oy;
    logic [ANG_W-1:0]        r_oang;
    logic signed [Q15_W-1:0] r_oz, r_ow;

    logic out_free;
    assign out_free = !r_ov || o_res.ready;

    // Quadrant fold and rounding of the CORDIC result
    logic signed [CX_W:0]    c_wide, s_wide;
    logic signed [Q15_W-1:0] c_q15, s_q15;
    always_comb begin
        case (r_q)
            2'd0: begin
                c_wide = (CX_W+1)'(r_cx);
                s_wide = (CX_W+1)'(r_cy);
            end
            2'd1: begin
                c_wide = -(CX_W+1)'(r_cy);
                s_wide = (CX_W+1)'(r_cx);
            end
            2'd2: begin
                c_wide = -(CX_W+1)'(r_cx);
                s_wide = -(CX_W+1)'(r_cy);
            end
            default: begin
                c_wide = (CX_W+1)'(r_cy);
                s_wide = -(CX_W+1)'(r_cx);
            end
        endcase
        c_q15 = to_q15(c_wide);
        s_q15 = to_q15(s_wide);
    end

    // Shared multiplier operand select
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic signed [MB_W-1:0] dt_s;
    assign dt_s = $signed({{(MB_W-DT_W){1'b0}}, r_dt});
    always_comb begin
        case (r_state)
            S_M0: begin
                mul_a = MA_W'(r_vx);
                mul_b = MB_W'(r_cos);
            end
            S_M1: begin
                mul_a = MA_W'(r_vy);
                mul_b = MB_W'(r_sin);
            end
            S_M2: begin
                mul_a = MA_W'(r_vx);
                mul_b = MB_W'(r_sin);
            end
            S_M3: begin
                mul_a = MA_W'(r_vy);
                mul_b = MB_W'(r_cos);
            end
            S_M4: begin
                mul_a = MA_W'(r_m0) - MA_W'(r_m1);
                mul_b = dt_s;
            end
            S_M5: begin
                mul_a = MA_W'(r_m2) + MA_W'(r_m3);
                mul_b = dt_s;
            end
            default: begin
                mul_a = MA_W'(r_wz);
                mul_b = dt_s;
            end
        endcase
        mul_p = MP_W'(mul_a) * MP_W'(mul_b);
    end

    // Rounded position delta from the held product
    logic signed [MP_W-1:0] rnd_sum;
    logic [POS_W-1:0]       pos_delta;
    assign rnd_sum   = r_prod + MP_W'(16384);
    assign pos_delta = POS_W'(rnd_sum >>> 15);

    // Heading increment and next heading
    logic signed [MP_W-1:0] dh_full;
    logic [HB-1:0]          head_next;
    assign dh_full   = (r_prod <<< SH_L) >>> SH_R;
    assign head_next = r_head + dh_full[HB-1:0];

    // Phases: heading before update, and half angle of heading after update
    logic [HB+15:0] ph_old_ext, ph_new_ext;
    logic [31:0]    phase_old, phase_new;
    assign ph_old_ext = {r_head, 16'b0};
    assign ph_new_ext = {head_next, 16'b0};
    assign phase_old  = ph_old_ext[F+31:F];
    assign phase_new  = ph_new_ext[F+32:F+1];

    // CORDIC load values
    logic [31:0]  ld_phase, ld_rr;
    logic [31:0]  ld_off;
    logic [1:0]   ld_q;
    assign ld_phase = (r_state == S_IDLE) ? phase_old : phase_new;
    assign ld_off   = ld_phase + 32'h2000_0000;
    assign ld_q     = ld_off[31:30];
    assign ld_rr    = ld_phase - {ld_q, 30'b0};

    // CORDIC iteration step
    logic signed [CX_W-1:0] sh_x, sh_y;
    logic [CZ_W-1:0]        atan_v;
    assign sh_x   = r_cx >>> r_step;
    assign sh_y   = r_cy >>> r_step;
    assign atan_v = atan_q(r_step);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // Next state and handshake
    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid)
                    n_state = S_ROT1;
            end
            S_ROT1:  if (r_step == LAST) n_state = S_FIN1;
            S_FIN1:  n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_M6;
            S_M6:    n_state = S_HEAD;
            S_HEAD:  n_state = S_ROT2;
            S_ROT2:  if (r_step == LAST) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Accumulators and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_head <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_state == S_M5)
                r_x <= r_x + pos_delta;
            if (r_state == S_M6)
                r_y <= r_y + pos_delta;
            if (r_state == S_HEAD)
                r_head <= head_next;
            if (r_state == S_DONE && out_free)
                r_ov <= 1'b1;
            else if (o_res.ready)
                r_ov <= 1'b0;
        end
    end

    // Datapath: capture, CORDIC, products, output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_dt <= i_in.dt_ticks;
            r_vx <= i_in.vel_x;
            r_vy <= i_in.vel_y;
            r_wz <= i_in.yaw_rate;
        end
        if ((r_state == S_IDLE && i_in.valid) || r_state == S_HEAD) begin
            r_cx   <= Q30_GAIN;
            r_cy   <= '0;
            r_cz   <= CZ_W'($signed(ld_rr));
            r_q    <= ld_q;
            r_step <= '0;
        end else if (r_state == S_ROT1 || r_state == S_ROT2) begin
            if (!r_cz[CZ_W-1]) begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_cz <= r_cz - $signed(atan_v);
            end else begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_cz <= r_cz + $signed(atan_v);
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (r_state == S_FIN1) begin
            r_sin <= s_q15;
            r_cos <= c_q15;
        end
        if (r_state == S_M0) r_m0 <= mul_p[31:0];
        if (r_state == S_M1) r_m1 <= mul_p[31:0];
        if (r_state == S_M2) r_m2 <= mul_p[31:0];
        if (r_state == S_M3) r_m3 <= mul_p[31:0];
        if (r_state == S_M4 || r_state == S_M5 || r_state == S_M6)
            r_prod <= mul_p;
        if (r_state == S_DONE && out_free) begin
            r_ox   <= r_x;
            r_oy   <= r_y;
            r_oang <= r_head[F+15:F];
            r_oz   <= s_q15;
            r_ow   <= c_q15;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.pos_x         = r_ox;
    assign o_res.pos_y         = r_oy;
    assign o_res.heading_angle = r_oang;
    assign o_res.quat_z        = r_oz;
    assign o_res.quat_w        = r_ow;

    // Busy after an accepted item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while busy");

    // Step counter stays inside the table
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT1 || r_state == S_ROT2) |-> r_step <= LAST)
        else $error("CORDIC step out of range");

    // A result appears only from the finishing state
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state) == S_DONE)
        else $error("result without finished item");

endmodule
`default_nettype wire
